@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge out of reset.
`define FFBA_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("allocator check failed");
// Check that one condition implies another in the next cycle.
`define FFBA_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("allocator check failed");
`else
`define FFBA_ASSERT_ALWAYS(name, cond)
`define FFBA_ASSERT_NEXT(name, pre, post)
`endif
`endif

@@ hw/rtl/ffba_pkg.sv @@
// Types and constants of the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 32;
    localparam int DEF_OFFSET_BITS  = 24;

    // Byte counts and block sizes fit 25 bits (heap is at most 2^24 bytes)
    localparam int SIZE_W = 25;

    localparam logic [24:0] HEAP_RESET = 25'd1048576;
    localparam logic [24:0] HEAP_MIN   = 25'd64;
    localparam logic [24:0] HEAP_MAX   = 25'd16777216;
    localparam logic [31:0] BASE_RESET = 32'h00F0_0000;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_NULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic CFG_HEAP_SIZE = 1'b0;
    localparam logic CFG_HEAP_BASE = 1'b1;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] sum;
        logic [31:0] diff;
        logic        ge;
        logic        eq;
    } alu_res_t;

endpackage

@@ hw/rtl/first_fit_block_allocator.sv @@
// Top level: first-fit block allocator with list walk sequencer.
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser command, tdata request/address
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata status, address, counts
// cfg       in         cfg_we                         cfg_index, cfg_wdata
//
// An allocate walks the block list, one table RAM read per block, and then
// either carves a new block behind the one that fits or, when the empty head
// takes it, fills the head; a free walks the list the same way and then merges
// the block into the one before it, or empties it when it is the head.
// One item is in flight at a time; s_axis_tready is high only when idle.
// The result register holds a finished item while m_axis stalls; the next item
// is still taken. Reset or a heap_size write leaves one empty head block at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int OFFSET_BITS  = DEF_OFFSET_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // request_bytes[23:0], release_address[55:24]
    input  logic        s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // status[1:0], granted_address[33:2],
                                        // used_bytes[58:34], free_bytes[83:59],
                                        // block_count[90:84], zero[95:91]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int SLOT_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LINK_W   = SLOT_W + 1;
    localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W    = OFFSET_BITS;
    localparam int PREV_LSB = 0;
    localparam int NEXT_LSB = LINK_W;
    localparam int UNU_LSB  = 2 * LINK_W;
    localparam int SIZE_LSB = UNU_LSB + SIZE_W;
    localparam int OFF_LSB  = SIZE_LSB + SIZE_W;
    localparam int REC_W    = OFF_LSB + OFF_W;

    localparam logic [LINK_W-1:0] NIL     = {1'b1, {SLOT_W{1'b0}}};
    localparam logic [SIZE_W-1:0] HDR_S   = SIZE_W'(HEADER_BYTES);
    localparam logic [31:0]       HDR_32  = 32'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0]  CNT_ONE = CNT_W'(1);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_A_NEED   = 5'd1;
    localparam logic [4:0] S_A_ROOM   = 5'd2;
    localparam logic [4:0] S_A_FIT    = 5'd3;
    localparam logic [4:0] S_A_WALK   = 5'd4;
    localparam logic [4:0] S_P_UNUSED = 5'd5;
    localparam logic [4:0] S_P_USED   = 5'd6;
    localparam logic [4:0] S_C_SLOT   = 5'd7;
    localparam logic [4:0] S_C_OFF1   = 5'd8;
    localparam logic [4:0] S_C_OFF2   = 5'd9;
    localparam logic [4:0] S_C_UNUSED = 5'd10;
    localparam logic [4:0] S_C_WFRESH = 5'd11;
    localparam logic [4:0] S_C_WCUR   = 5'd12;
    localparam logic [4:0] S_C_WNEXT  = 5'd13;
    localparam logic [4:0] S_C_USED   = 5'd14;
    localparam logic [4:0] S_G_BASE   = 5'd15;
    localparam logic [4:0] S_G_HDR    = 5'd16;
    localparam logic [4:0] S_F_BASE   = 5'd17;
    localparam logic [4:0] S_F_KEY    = 5'd18;
    localparam logic [4:0] S_F_WALK   = 5'd19;
    localparam logic [4:0] S_H_UNUSED = 5'd20;
    localparam logic [4:0] S_H_USED   = 5'd21;
    localparam logic [4:0] S_M_PREV   = 5'd22;
    localparam logic [4:0] S_M_SUM1   = 5'd23;
    localparam logic [4:0] S_M_SUM2   = 5'd24;
    localparam logic [4:0] S_M_SUM3   = 5'd25;
    localparam logic [4:0] S_M_HDR    = 5'd26;
    localparam logic [4:0] S_M_USED   = 5'd27;
    localparam logic [4:0] S_DONE     = 5'd28;

    function automatic logic [REC_W-1:0] pack_rec(
        input logic [OFF_W-1:0]  off,
        input logic [SIZE_W-1:0] size,
        input logic [SIZE_W-1:0] unused,
        input logic [LINK_W-1:0] nxt,
        input logic [LINK_W-1:0] prv
    );
        return {off, size, unused, nxt, prv};
    endfunction

    // control state
    logic [4:0]        state_reg, state_next;
    logic [24:0]       heap_size_reg, heap_size_next;
    logic [31:0]       heap_base_reg, heap_base_next;
    logic [SIZE_W-1:0] init_unused_reg, init_unused_next;
    logic [SIZE_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  hw_reg, hw_next;
    logic [CNT_W-1:0]  sp_reg, sp_next;
    logic              head_fresh_reg, head_fresh_next;
    logic              out_valid_reg, out_valid_next;

    // payload state
    logic [23:0]       n_reg, n_next;
    logic [31:0]       addr_reg, addr_next;
    logic [SIZE_W-1:0] need_reg, need_next;
    logic [31:0]       tmp_reg, tmp_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] unused_reg, unused_next;
    logic [LINK_W-1:0] nlink_reg, nlink_next;
    logic [LINK_W-1:0] plink_reg, plink_next;
    logic [REC_W-1:0]  prv_rec_reg, prv_rec_next;
    logic [SLOT_W-1:0] fresh_reg, fresh_next;
    logic              from_stk_reg, from_stk_next;
    logic [OFF_W-1:0]  grant_off_reg, grant_off_next;
    logic [1:0]        status_reg, status_next;
    logic [31:0]       granted_reg, granted_next;
    logic [95:0]       out_data_reg, out_data_next;

    // memory ports
    logic              tab_we, tab_re, stk_we, stk_re;
    logic [SLOT_W-1:0] tab_waddr, tab_raddr, stk_waddr, stk_raddr;
    logic [REC_W-1:0]  tab_wdata, tab_q, q_eff;
    logic [SLOT_W-1:0] stk_wdata, stk_q;

    alu_req_t alu_req;
    alu_res_t alu_res;

    logic [OFF_W-1:0]  q_off;
    logic [SIZE_W-1:0] q_size, q_unused;
    logic [LINK_W-1:0] q_next, q_prev;
    logic [24:0]       cfg_heap;
    logic [SIZE_W-1:0] free_val;

    ffba_ram #(.WIDTH(REC_W), .DEPTH(MAX_BLOCKS)) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_q)
    );

    // freed slots, reused last in first out
    ffba_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_BLOCKS)) u_slot_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_q)
    );

    ffba_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // head slot reads as the empty heap block until first written
    assign q_eff    = (head_fresh_reg && rd_slot_reg == '0)
                      ? pack_rec('0, '0, init_unused_reg, NIL, NIL) : tab_q;
    assign q_off    = q_eff[OFF_LSB +: OFF_W];
    assign q_size   = q_eff[SIZE_LSB +: SIZE_W];
    assign q_unused = q_eff[UNU_LSB +: SIZE_W];
    assign q_next   = q_eff[NEXT_LSB +: LINK_W];
    assign q_prev   = q_eff[PREV_LSB +: LINK_W];

    assign free_val = alu_res.ge ? alu_res.diff[SIZE_W-1:0] : '0;

    always_comb
    begin
        cfg_heap = cfg_wdata[24:0];
        if (cfg_heap < HEAP_MIN)
        begin
            cfg_heap = HEAP_MIN;
        end
        else if (cfg_heap > HEAP_MAX)
        begin
            cfg_heap = HEAP_MAX;
        end
    end

    // operand selection for the shared unit
    always_comb
    begin
        alu_req.a = '0;
        alu_req.b = '0;
        unique case (state_reg)
            S_A_NEED:   begin alu_req.a = 32'(n_reg);      alu_req.b = HDR_32;             end
            S_A_ROOM:   begin alu_req.a = 32'(heap_size_reg); alu_req.b = 32'(used_reg);   end
            S_A_FIT:    begin alu_req.a = tmp_reg;         alu_req.b = 32'(n_reg);         end
            S_A_WALK:   begin alu_req.a = 32'(q_unused);   alu_req.b = 32'(need_reg);      end
            S_P_UNUSED: begin alu_req.a = 32'(unused_reg); alu_req.b = 32'(n_reg);         end
            S_P_USED:   begin alu_req.a = 32'(used_reg);   alu_req.b = 32'(n_reg);         end
            S_C_OFF1:   begin alu_req.a = 32'(off_reg);    alu_req.b = HDR_32;             end
            S_C_OFF2:   begin alu_req.a = tmp_reg;         alu_req.b = 32'(size_reg);      end
            S_C_UNUSED: begin alu_req.a = 32'(unused_reg); alu_req.b = 32'(need_reg);      end
            S_C_USED:   begin alu_req.a = 32'(used_reg);   alu_req.b = 32'(need_reg);      end
            S_G_BASE:   begin alu_req.a = heap_base_reg;   alu_req.b = 32'(grant_off_reg); end
            S_G_HDR:    begin alu_req.a = tmp_reg;         alu_req.b = HDR_32;             end
            S_F_BASE:   begin alu_req.a = addr_reg;        alu_req.b = heap_base_reg;      end
            S_F_KEY:    begin alu_req.a = tmp_reg;         alu_req.b = HDR_32;             end
            S_F_WALK:   begin alu_req.a = 32'(q_off);      alu_req.b = tmp_reg;            end
            S_H_UNUSED: begin alu_req.a = 32'(unused_reg); alu_req.b = 32'(size_reg);      end
            S_H_USED:   begin alu_req.a = 32'(used_reg);   alu_req.b = 32'(size_reg);      end
            S_M_SUM1:   begin alu_req.a = 32'(size_reg);   alu_req.b = 32'(unused_reg);    end
            S_M_SUM2:   begin alu_req.a = tmp_reg;         alu_req.b = HDR_32;             end
            S_M_SUM3:
            begin
                alu_req.a = 32'(prv_rec_reg[UNU_LSB +: SIZE_W]);
                alu_req.b = tmp_reg;
            end
            S_M_HDR:    begin alu_req.a = 32'(size_reg);   alu_req.b = HDR_32;             end
            S_M_USED:   begin alu_req.a = 32'(used_reg);   alu_req.b = tmp_reg;            end
            S_DONE:     begin alu_req.a = 32'(heap_size_reg); alu_req.b = 32'(used_reg);   end
            default:    begin alu_req.a = '0;              alu_req.b = '0;                 end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        heap_size_next   = heap_size_reg;
        heap_base_next   = heap_base_reg;
        init_unused_next = init_unused_reg;
        used_next        = used_reg;
        count_next       = count_reg;
        hw_next          = hw_reg;
        sp_next          = sp_reg;
        head_fresh_next  = head_fresh_reg;
        out_valid_next   = out_valid_reg;
        n_next           = n_reg;
        addr_next        = addr_reg;
        need_next        = need_reg;
        tmp_next         = tmp_reg;
        cur_next         = cur_reg;
        rd_slot_next     = rd_slot_reg;
        off_next         = off_reg;
        size_next        = size_reg;
        unused_next      = unused_reg;
        nlink_next       = nlink_reg;
        plink_next       = plink_reg;
        prv_rec_next     = prv_rec_reg;
        fresh_next       = fresh_reg;
        from_stk_next    = from_stk_reg;
        grant_off_next   = grant_off_reg;
        status_next      = status_reg;
        granted_next     = granted_reg;
        out_data_next    = out_data_reg;
        tab_we           = 1'b0;
        tab_waddr        = cur_reg;
        tab_wdata        = '0;
        tab_re           = 1'b0;
        tab_raddr        = '0;
        stk_we           = 1'b0;
        stk_waddr        = sp_reg[SLOT_W-1:0];
        stk_wdata        = cur_reg;
        stk_re           = 1'b0;
        stk_raddr        = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    n_next       = s_axis_tdata[23:0];
                    addr_next    = s_axis_tdata[55:24];
                    granted_next = '0;
                    if (s_axis_tuser == CMD_ALLOC)
                    begin
                        state_next = S_A_NEED;
                    end
                    else if (s_axis_tdata[55:24] == '0)
                    begin
                        status_next = ST_NULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_F_BASE;
                    end
                end
            end
            S_A_NEED:
            begin
                need_next  = alu_res.sum[SIZE_W-1:0];
                state_next = S_A_ROOM;
            end
            S_A_ROOM:
            begin
                tmp_next   = alu_res.ge ? alu_res.diff : '0;
                state_next = S_A_FIT;
            end
            S_A_FIT:
            begin
                if (!alu_res.ge || n_reg == '0)
                begin
                    status_next = ST_REFUSED;
                    state_next  = S_DONE;
                end
                else
                begin
                    tab_re       = 1'b1;
                    tab_raddr    = '0;
                    rd_slot_next = '0;
                    cur_next     = '0;
                    state_next   = S_A_WALK;
                end
            end
            S_A_WALK:
            begin
                if (alu_res.ge)
                begin
                    off_next       = q_off;
                    size_next      = q_size;
                    unused_next    = q_unused;
                    nlink_next     = q_next;
                    plink_next     = q_prev;
                    grant_off_next = q_off;
                    state_next     = (q_size == '0) ? S_P_UNUSED : S_C_SLOT;
                end
                else if (q_next[LINK_W-1])
                begin
                    status_next = ST_REFUSED;
                    state_next  = S_DONE;
                end
                else
                begin
                    tab_re       = 1'b1;
                    tab_raddr    = q_next[SLOT_W-1:0];
                    rd_slot_next = q_next[SLOT_W-1:0];
                    cur_next     = q_next[SLOT_W-1:0];
                end
            end
            S_P_UNUSED:
            begin
                tab_we     = 1'b1;
                tab_waddr  = cur_reg;
                tab_wdata  = pack_rec(off_reg, SIZE_W'(n_reg), alu_res.diff[SIZE_W-1:0],
                                      nlink_reg, plink_reg);
                state_next = S_P_USED;
            end
            S_P_USED:
            begin
                used_next  = alu_res.sum[SIZE_W-1:0];
                state_next = S_G_BASE;
            end
            S_C_SLOT:
            begin
                if (count_reg == CNT_MAX)
                begin
                    status_next = ST_REFUSED;
                    state_next  = S_DONE;
                end
                else
                begin
                    // take a freed slot if any, else the next never-used one
                    count_next = count_reg + CNT_ONE;
                    if (sp_reg != '0)
                    begin
                        stk_re        = 1'b1;
                        stk_raddr     = SLOT_W'(sp_reg - CNT_ONE);
                        sp_next       = sp_reg - CNT_ONE;
                        from_stk_next = 1'b1;
                    end
                    else
                    begin
                        fresh_next    = hw_reg[SLOT_W-1:0];
                        hw_next       = hw_reg + CNT_ONE;
                        from_stk_next = 1'b0;
                    end
                    state_next = S_C_OFF1;
                end
            end
            S_C_OFF1:
            begin
                tmp_next = alu_res.sum;
                if (from_stk_reg)
                begin
                    fresh_next = stk_q;
                end
                state_next = S_C_OFF2;
            end
            S_C_OFF2:
            begin
                grant_off_next = alu_res.sum[OFF_W-1:0];
                state_next     = S_C_UNUSED;
            end
            S_C_UNUSED:
            begin
                tmp_next   = alu_res.diff;
                state_next = S_C_WFRESH;
            end
            S_C_WFRESH:
            begin
                tab_we    = 1'b1;
                tab_waddr = fresh_reg;
                tab_wdata = pack_rec(grant_off_reg, SIZE_W'(n_reg), tmp_reg[SIZE_W-1:0],
                                     nlink_reg, {1'b0, cur_reg});
                if (!nlink_reg[LINK_W-1])
                begin
                    tab_re       = 1'b1;
                    tab_raddr    = nlink_reg[SLOT_W-1:0];
                    rd_slot_next = nlink_reg[SLOT_W-1:0];
                end
                state_next = S_C_WCUR;
            end
            S_C_WCUR:
            begin
                tab_we     = 1'b1;
                tab_waddr  = cur_reg;
                tab_wdata  = pack_rec(off_reg, size_reg, '0, {1'b0, fresh_reg}, plink_reg);
                state_next = nlink_reg[LINK_W-1] ? S_C_USED : S_C_WNEXT;
            end
            S_C_WNEXT:
            begin
                tab_we     = 1'b1;
                tab_waddr  = nlink_reg[SLOT_W-1:0];
                tab_wdata  = pack_rec(q_off, q_size, q_unused, q_next, {1'b0, fresh_reg});
                state_next = S_C_USED;
            end
            S_C_USED:
            begin
                used_next  = alu_res.sum[SIZE_W-1:0];
                state_next = S_G_BASE;
            end
            S_G_BASE:
            begin
                tmp_next   = alu_res.sum;
                state_next = S_G_HDR;
            end
            S_G_HDR:
            begin
                granted_next = alu_res.sum;
                status_next  = ST_OK;
                state_next   = S_DONE;
            end
            S_F_BASE:
            begin
                tmp_next   = alu_res.diff;
                state_next = S_F_KEY;
            end
            S_F_KEY:
            begin
                // key is the block offset whose payload address matches
                tmp_next     = alu_res.diff;
                tab_re       = 1'b1;
                tab_raddr    = '0;
                rd_slot_next = '0;
                cur_next     = '0;
                state_next   = S_F_WALK;
            end
            S_F_WALK:
            begin
                if (alu_res.eq)
                begin
                    off_next    = q_off;
                    size_next   = q_size;
                    unused_next = q_unused;
                    nlink_next  = q_next;
                    plink_next  = q_prev;
                    if (q_prev[LINK_W-1])
                    begin
                        state_next = S_H_UNUSED;
                    end
                    else
                    begin
                        tab_re       = 1'b1;
                        tab_raddr    = q_prev[SLOT_W-1:0];
                        rd_slot_next = q_prev[SLOT_W-1:0];
                        state_next   = S_M_PREV;
                    end
                end
                else if (q_next[LINK_W-1])
                begin
                    status_next = ST_UNKNOWN;
                    state_next  = S_DONE;
                end
                else
                begin
                    tab_re       = 1'b1;
                    tab_raddr    = q_next[SLOT_W-1:0];
                    rd_slot_next = q_next[SLOT_W-1:0];
                    cur_next     = q_next[SLOT_W-1:0];
                end
            end
            S_H_UNUSED:
            begin
                tab_we     = 1'b1;
                tab_waddr  = cur_reg;
                tab_wdata  = pack_rec(off_reg, '0, alu_res.sum[SIZE_W-1:0],
                                      nlink_reg, plink_reg);
                state_next = S_H_USED;
            end
            S_H_USED:
            begin
                used_next   = alu_res.diff[SIZE_W-1:0];
                status_next = ST_OK;
                state_next  = S_DONE;
            end
            S_M_PREV:
            begin
                prv_rec_next = q_eff;
                if (!nlink_reg[LINK_W-1])
                begin
                    tab_re       = 1'b1;
                    tab_raddr    = nlink_reg[SLOT_W-1:0];
                    rd_slot_next = nlink_reg[SLOT_W-1:0];
                end
                state_next = S_M_SUM1;
            end
            S_M_SUM1:
            begin
                tmp_next = alu_res.sum;
                if (!nlink_reg[LINK_W-1])
                begin
                    tab_we    = 1'b1;
                    tab_waddr = nlink_reg[SLOT_W-1:0];
                    tab_wdata = pack_rec(q_off, q_size, q_unused, q_next, plink_reg);
                end
                // release the slot
                stk_we     = 1'b1;
                stk_waddr  = sp_reg[SLOT_W-1:0];
                stk_wdata  = cur_reg;
                sp_next    = sp_reg + CNT_ONE;
                count_next = count_reg - CNT_ONE;
                state_next = S_M_SUM2;
            end
            S_M_SUM2:
            begin
                tmp_next   = alu_res.sum;
                state_next = S_M_SUM3;
            end
            S_M_SUM3:
            begin
                tab_we     = 1'b1;
                tab_waddr  = plink_reg[SLOT_W-1:0];
                tab_wdata  = pack_rec(prv_rec_reg[OFF_LSB +: OFF_W],
                                      prv_rec_reg[SIZE_LSB +: SIZE_W],
                                      alu_res.sum[SIZE_W-1:0], nlink_reg,
                                      prv_rec_reg[PREV_LSB +: LINK_W]);
                state_next = S_M_HDR;
            end
            S_M_HDR:
            begin
                tmp_next   = alu_res.sum;
                state_next = S_M_USED;
            end
            S_M_USED:
            begin
                used_next   = alu_res.diff[SIZE_W-1:0];
                status_next = ST_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'b0, 7'(count_reg), free_val, used_reg,
                                      granted_reg, status_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (tab_we && tab_waddr == '0)
        begin
            head_fresh_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAP_SIZE:
                begin
                    heap_size_next   = cfg_heap;
                    init_unused_next = cfg_heap - HDR_S;
                    head_fresh_next  = 1'b1;
                    used_next        = HDR_S;
                    count_next       = CNT_ONE;
                    hw_next          = CNT_ONE;
                    sp_next          = '0;
                end
                CFG_HEAP_BASE:
                begin
                    heap_base_next = cfg_wdata;
                end
                default:
                begin
                    heap_base_next = heap_base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            heap_size_reg   <= HEAP_RESET;
            heap_base_reg   <= BASE_RESET;
            init_unused_reg <= HEAP_RESET - HDR_S;
            used_reg        <= HDR_S;
            count_reg       <= CNT_ONE;
            hw_reg          <= CNT_ONE;
            sp_reg          <= '0;
            head_fresh_reg  <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            heap_size_reg   <= heap_size_next;
            heap_base_reg   <= heap_base_next;
            init_unused_reg <= init_unused_next;
            used_reg        <= used_next;
            count_reg       <= count_next;
            hw_reg          <= hw_next;
            sp_reg          <= sp_next;
            head_fresh_reg  <= head_fresh_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        addr_reg      <= addr_next;
        need_reg      <= need_next;
        tmp_reg       <= tmp_next;
        cur_reg       <= cur_next;
        rd_slot_reg   <= rd_slot_next;
        off_reg       <= off_next;
        size_reg      <= size_next;
        unused_reg    <= unused_next;
        nlink_reg     <= nlink_next;
        plink_reg     <= plink_next;
        prv_rec_reg   <= prv_rec_next;
        fresh_reg     <= fresh_next;
        from_stk_reg  <= from_stk_next;
        grant_off_reg <= grant_off_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        out_data_reg  <= out_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `FFBA_ASSERT_ALWAYS(a_used_fits, used_reg <= heap_size_reg)
    `FFBA_ASSERT_ALWAYS(a_count_range, count_reg != '0 && count_reg <= CNT_MAX)
    `FFBA_ASSERT_ALWAYS(a_slot_balance, hw_reg - sp_reg == count_reg)
    `FFBA_ASSERT_NEXT(a_result_on_done, state_reg == S_DONE && !out_valid_reg, out_valid_reg)

endmodule

@@ hw/rtl/ffba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/ffba_alu.sv @@
// Shared add, subtract and compare unit of the allocator sequencer.
`timescale 1ns / 1ps
module ffba_alu
    import ffba_pkg::*;
(
    input  alu_req_t req,
    output alu_res_t res
);

    always_comb
    begin
        res.sum  = req.a + req.b;
        res.diff = req.a - req.b;
        res.ge   = (req.a >= req.b);
        res.eq   = (req.a == req.b);
    end

endmodule
